[rtl/tfh_pkg.sv]
// Package: shared constants for the terrain floor height block
`timescale 1ns / 1ps
`default_nettype none
package tfh_pkg;
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PROBE  = 2'd3;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
endpackage
`default_nettype wire

[rtl/tfh_ram.sv]
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module tfh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/terrain_floor_height.sv]
// Top level: heightmap store and nine-sample bilinear floor query
`timescale 1ns / 1ps
`default_nettype none
// A write (func 0) gives no result. A query (func 1)
// visits nine probe points, one at a time. Each probe point first gets its
// range check in S_POINT. A valid one then reads its four corner heights
// through the single registered heightmap RAM port in S_READ, and goes on
// to the interpolation multiplies in S_MUL1 and S_MUL2. An invalid probe
// point goes straight on to the next one. After the last probe point, S_DONE
// ends the query. Then done pulses for one cycle with floor_value and
// floor_valid. busy is already low in that cycle, so the next item can
// start in that cycle. The receiver cannot stall
// and must take the result in that cycle.
module terrain_floor_height #(
  parameter int MAX_COLUMNS        = 256,
  parameter int MAX_ROWS           = 256,
  parameter int NEAR_INTEGER_LIMIT = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic [15:0]        entry_address,
  input  wire logic signed [15:0] entry_height,
  input  wire logic signed [18:0] query_x,
  input  wire logic signed [18:0] query_z,
  output logic                    done,
  output logic signed [15:0]      floor_value,
  output logic                    floor_valid,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_POINT, S_READ, S_MUL1, S_MUL2, S_DONE} state_t;

  localparam int MC = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
  localparam int MR = (MAX_ROWS < 511) ? MAX_ROWS : 511;

  state_t state;
  logic world_enable;
  logic [8:0] map_width, map_height;
  logic [11:0] probe_offset;
  logic signed [18:0] qx, qz;
  logic [1:0] dx, dz;
  logic [2:0] corner;
  logic [7:0] fx, fz;
  logic [15:0] base;
  logic signed [15:0] h0, h1, h2, h3;
  logic signed [26:0] srow, nrow;
  logic signed [15:0] best;
  logic any;

  logic [8:0] w_eff, h_eff;
  assign w_eff = (map_width > 9'(MC)) ? 9'(MC) : map_width;
  assign h_eff = (map_height > 9'(MR)) ? 9'(MR) : map_height;

  logic signed [20:0] px, pz;
  always_comb begin
    px = 21'(qx);
    pz = 21'(qz);
    if (dx == 2'd0) px = 21'(qx) - 21'(probe_offset);
    else if (dx == 2'd2) px = 21'(qx) + 21'(probe_offset);
    if (dz == 2'd0) pz = 21'(qz) - 21'(probe_offset);
    else if (dz == 2'd2) pz = 21'(qz) + 21'(probe_offset);
  end

  logic [20:0] xlim, zlim;
  logic pvalid;
  assign xlim = (w_eff == 9'd0) ? 21'd0 : {4'd0, w_eff - 9'd1, 8'd0};
  assign zlim = (h_eff == 9'd0) ? 21'd0 : {4'd0, h_eff - 9'd1, 8'd0};
  assign pvalid = world_enable && (w_eff != 9'd0) && (h_eff != 9'd0) && !px[20] && !pz[20]
                  && (px <= $signed(xlim)) && (pz <= $signed(zlim));

  function automatic logic near(input logic [7:0] f);
    near = (9'(f) < 9'(NEAR_INTEGER_LIMIT)) ||
           ((f != 8'd0) && ((9'd256 - 9'(f)) < 9'(NEAR_INTEGER_LIMIT)));
  endfunction

  logic [15:0] raddr;
  always_comb begin
    raddr = base;
    unique case (corner[1:0])
      2'd0: raddr = base;
      2'd1: raddr = base + 16'(fx != 8'd0);
      2'd2: raddr = base + ((fz != 8'd0) ? 16'(w_eff) : 16'd0);
      default: raddr = base + ((fz != 8'd0) ? 16'(w_eff) : 16'd0) + 16'(fx != 8'd0);
    endcase
  end

  logic ram_we;
  logic [15:0] ram_addr;
  logic [15:0] ram_q;
  assign ram_we = (state == S_IDLE) && start && (func == tfh_pkg::FUNC_WRITE);
  assign ram_addr = ram_we ? entry_address : raddr;
  tfh_ram #(.WIDTH(16), .DEPTH(65536)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(entry_height), .rdata(ram_q)
  );

  logic signed [26:0] s_mix, n_mix;
  logic signed [9:0] wx0, wx1, wz0, wz1;
  assign wx1 = near(fx) ? 10'sd0 : $signed({2'b0, fx});
  assign wx0 = 10'sd256 - wx1;
  assign wz1 = near(fz) ? 10'sd128 : $signed({2'b0, fz});
  assign wz0 = near(fz) ? 10'sd128 : 10'sd256 - wz1;
  assign s_mix = 27'(h0 * wx0) + 27'(h1 * wx1);
  assign n_mix = 27'(h2 * wx0) + 27'(h3 * wx1);

  logic signed [37:0] tsum, trnd;
  logic signed [15:0] sval;
  assign tsum = 38'(srow * wz0) + 38'(nrow * wz1);
  assign trnd = (tsum + 38'sd32768) >>> 16;
  assign sval = trnd[15:0];

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      world_enable <= 1'b1;
      map_width <= 9'd256;
      map_height <= 9'd256;
      probe_offset <= 12'd256;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tfh_pkg::REG_ENABLE: world_enable <= cfg_data[0];
          tfh_pkg::REG_WIDTH:  map_width <= cfg_data[8:0];
          tfh_pkg::REG_HEIGHT: map_height <= cfg_data[8:0];
          tfh_pkg::REG_PROBE:  probe_offset <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start && func == tfh_pkg::FUNC_QUERY) begin
            qx <= query_x;
            qz <= query_z;
            dx <= 2'd0;
            dz <= 2'd0;
            any <= 1'b0;
            best <= 16'sd0;
            state <= S_POINT;
          end
        end
        S_POINT: begin
          if (pvalid) begin
            fx <= px[7:0];
            fz <= pz[7:0];
            base <= 16'(pz[16:8] * w_eff) + 16'(px[16:8]);
            corner <= 3'd0;
            state <= S_READ;
          end else if (dx == 2'd2 && dz == 2'd2) begin
            state <= S_DONE;
          end else if (dx == 2'd2) begin
            dx <= 2'd0;
            dz <= dz + 2'd1;
          end else begin
            dx <= dx + 2'd1;
          end
        end
        S_READ: begin
          corner <= corner + 3'd1;
          unique case (corner)
            3'd1: h0 <= ram_q;
            3'd2: h1 <= ram_q;
            3'd3: h2 <= ram_q;
            3'd4: h3 <= ram_q;
            default: ;
          endcase
          if (corner == 3'd4) state <= S_MUL1;
        end
        S_MUL1: begin
          srow <= s_mix;
          nrow <= n_mix;
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (!any || sval > best) best <= sval;
          any <= 1'b1;
          if (dx == 2'd2 && dz == 2'd2) begin
            state <= S_DONE;
          end else begin
            state <= S_POINT;
            if (dx == 2'd2) begin
              dx <= 2'd0;
              dz <= dz + 2'd1;
            end else begin
              dx <= dx + 2'd1;
            end
          end
        end
        default: begin
          floor_value <= any ? best : 16'sd0;
          floor_valid <= any;
          done <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
